>>> design/sirx_pkg.sv
package sirx_pkg;

  localparam int unsigned CAPACITY_DEF    = 256;
  localparam int unsigned MAX_RESULTS_DEF = 64;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned LIMIT_W = 7;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_COUNT  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_ZERO_LIM  = 2'd2,
    ST_RESERVED  = 2'd3
  } status_t;

  localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

endpackage

>>> design/sorted_int_range_index.sv
// sorted index of (signed 64-bit key, 32-bit vector id) pairs held in one
// simple dual-port synchronous memory (one read and one write per cycle,
// registered read data). every input transaction yields one or more result
// transactions on the master side; the last one carries tlast. steps:
// insert is a binary search and then a shift of the tail, each moved entry
// read and then written one place up; remove is one compaction sweep over
// the table, each entry read and, if its id differs, written down to the
// write pointer; lookup is two binary searches (lower and upper bound) then
// one result per emitted id, held while the receiver stalls; count goes
// straight to its single result.
// no clearing pass after reset: only entries below the entry count are used.
// a new input is taken only once the previous transaction's results are out
// of the working state; one result may still wait in the output register.
module sorted_int_range_index #(
  parameter int unsigned CAPACITY        = sirx_pkg::CAPACITY_DEF,
  parameter int unsigned MAX_RESULTS_OUT = sirx_pkg::MAX_RESULTS_DEF,
  parameter int unsigned AW              = $clog2(CAPACITY),
  parameter int unsigned CW              = $clog2(CAPACITY + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // mode[1:0], key_value[65:2], key_high[129:66], vector_id[161:130],
  // result_limit[168:162], zero fill to 176
  input  logic [175:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // status[1:0], found[2], match_id[34:3], entry_total[43:35], zero fill to 48
  output logic [47:0]   m_tdata,
  output logic          m_tlast
);
  import sirx_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_INS_RD, S_INS_WR, S_INS_PUT,
    S_REM_RD, S_REM_CHK, S_LK_HI, S_EMIT_RD, S_EMIT_OUT, S_DONE
  } state_t;

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [LIMIT_W-1:0] MAXR_C = LIMIT_W'(MAX_RESULTS_OUT);

  // table memory, key and id kept side by side in one word
  logic [KEY_W+ID_W-1:0] mem [CAPACITY];
  logic [KEY_W+ID_W-1:0] rd_data;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [KEY_W+ID_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  state_t state;
  logic [CW-1:0]      count;
  mode_t              mode;
  logic [KEY_W-1:0]   klo, khi, skey;
  logic [ID_W-1:0]    vid;
  logic [LIMIT_W-1:0] limit, emitted;
  logic               strict;
  logic [CW-1:0]      lo, hi, lo_bound, idx, wptr;

  // output register
  logic       ov;
  status_t    o_status;
  logic       o_found;
  logic [ID_W-1:0] o_id;
  logic [CW-1:0]   o_total;
  logic       o_last;

  logic out_free;
  assign out_free = !ov || m_tready;
  assign s_tready = (state == S_IDLE);

  // a result is loaded into the output register this cycle
  logic fire;
  assign fire = out_free && (state == S_EMIT_OUT || state == S_DONE);

  logic [KEY_W-1:0] rd_key;
  logic [ID_W-1:0]  rd_id;
  assign rd_key = rd_data[KEY_W+ID_W-1:ID_W];
  assign rd_id  = rd_data[ID_W-1:0];

  logic [CW-1:0] mid;
  assign mid = lo + ((hi - lo) >> 1);

  logic go_right;
  assign go_right = strict ? (rd_key <= skey) : (rd_key < skey);

  // shift reads the entry below idx; emit keeps the read at idx while stalled
  always_comb begin
    rd_addr = mid[AW-1:0];
    unique case (state)
      S_INS_RD: rd_addr = idx[AW-1:0] - 1'b1;
      S_REM_RD, S_EMIT_RD, S_EMIT_OUT: rd_addr = idx[AW-1:0];
      default: rd_addr = mid[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ov    <= 1'b0;
      wr_en <= 1'b0;
    end else begin
      ov    <= (ov && !m_tready) || fire;
      wr_en <= (state == S_INS_WR) || (state == S_INS_PUT) ||
               (state == S_REM_CHK && rd_id != vid);
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          mode  <= mode_t'(s_tdata[1:0]);
          klo   <= s_tdata[65:2] ^ SIGN_FLIP;
          khi   <= s_tdata[129:66] ^ SIGN_FLIP;
          vid   <= s_tdata[161:130];
          limit <= (s_tdata[168:162] > MAXR_C) ? MAXR_C : s_tdata[168:162];
          skey  <= s_tdata[65:2] ^ SIGN_FLIP;
          strict <= 1'b0;
          lo <= '0;
          hi <= count;
          idx <= '0;
          wptr <= '0;
          emitted <= '0;
          unique case (mode_t'(s_tdata[1:0]))
            MODE_INSERT: state <= (count >= CAP_C) ? S_DONE : S_SRCH_RD;
            MODE_REMOVE: state <= S_REM_RD;
            MODE_LOOKUP: state <= (s_tdata[168:162] == '0) ? S_DONE : S_SRCH_RD;
            default:     state <= S_DONE;
          endcase
        end
        S_SRCH_RD: begin
          if (lo < hi) state <= S_SRCH_CMP;
          else if (mode == MODE_INSERT) begin
            idx <= count;
            state <= (count > lo) ? S_INS_RD : S_INS_PUT;
          end else if (!strict) begin
            lo_bound <= lo;
            strict <= 1'b1;
            skey <= khi;
            hi <= count;
            state <= S_LK_HI;
          end else begin
            hi <= lo;
            idx <= lo_bound;
            state <= S_EMIT_RD;
          end
        end
        S_SRCH_CMP: begin
          if (go_right) lo <= mid + 1'b1;
          else hi <= mid;
          state <= S_SRCH_RD;
        end
        S_LK_HI: begin
          lo <= lo_bound;
          state <= S_SRCH_RD;
        end
        // shift tail up by one, reading idx-1 and writing idx
        S_INS_RD: begin
          idx <= idx - 1'b1;
          state <= S_INS_WR;
        end
        S_INS_WR: begin
          wr_addr <= AW'(idx + 1'b1);
          wr_data <= rd_data;
          state <= (idx > lo) ? S_INS_RD : S_INS_PUT;
        end
        S_INS_PUT: begin
          wr_addr <= lo[AW-1:0];
          wr_data <= {klo, vid};
          count <= count + 1'b1;
          state <= S_DONE;
        end
        S_REM_RD: begin
          if (idx < count) state <= S_REM_CHK;
          else begin
            count <= wptr;
            state <= S_DONE;
          end
        end
        S_REM_CHK: begin
          if (rd_id != vid) begin
            wr_addr <= wptr[AW-1:0];
            wr_data <= rd_data;
            wptr <= wptr + 1'b1;
          end
          idx <= idx + 1'b1;
          state <= S_REM_RD;
        end
        S_EMIT_RD: begin
          if (idx < hi && emitted < limit) state <= S_EMIT_OUT;
          else if (emitted == '0) state <= S_DONE;
          else state <= S_IDLE;
        end
        S_EMIT_OUT: if (out_free) begin
          o_status <= ST_OK;
          o_found <= 1'b1;
          o_id <= rd_id;
          o_total <= count;
          o_last <= (idx + 1'b1 >= hi) || (emitted + 1'b1 >= limit);
          emitted <= emitted + 1'b1;
          idx <= idx + 1'b1;
          state <= S_EMIT_RD;
        end
        S_DONE: if (out_free) begin
          o_status <= (mode == MODE_INSERT && count >= CAP_C && state == S_DONE
                       && lo == '0 && hi == count && idx == '0) ? ST_FULL :
                      (mode == MODE_LOOKUP && limit == '0) ? ST_ZERO_LIM : ST_OK;
          o_found <= 1'b0;
          o_id <= '0;
          o_total <= count;
          o_last <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = ov;
  assign m_tlast  = o_last;
  assign m_tdata  = {4'b0, 9'(o_total), o_id, o_found, o_status};

  assert property (@(posedge clk) disable iff (rst) count <= CAP_C)
    else $error("entry count above capacity");
  assert property (@(posedge clk) disable iff (rst)
    (ov && !m_tready) |=> (ov && $stable(m_tdata)))
    else $error("held result changed");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_OUT) |-> (emitted < limit))
    else $error("emitting past limit");
endmodule

>>> bench/sorted_int_range_index_chk.sv
module sorted_int_range_index_chk (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [175:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [47:0]  m_tdata,
  input  logic         m_tlast,
  output int           fail_count,
  output int           pending
);
  import sirx_pkg::*;

  typedef struct packed {
    status_t     status;
    logic        found;
    logic [31:0] match_id;
    logic [8:0]  entry_total;
    logic        last;
  } index_result_t;

  logic signed [63:0] keys[$];
  logic [31:0]        ids[$];
  index_result_t      result_q[$];

  assign pending = result_q.size();

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic index_result_t mk(status_t st, logic f, logic [31:0] id, logic l);
    index_result_t r;
    r.status = st; r.found = f; r.match_id = id;
    r.entry_total = 9'(keys.size()); r.last = l;
    return r;
  endfunction

  // apply one command to the table copy and queue the results it causes
  task automatic apply_command(input logic [175:0] d);
    mode_t              md;
    logic signed [63:0] klo, khi;
    logic [31:0]        vid;
    int                 lim, pos, n;
    md  = mode_t'(d[1:0]);
    klo = d[65:2];
    khi = d[129:66];
    vid = d[161:130];
    lim = d[168:162];
    case (md)
      MODE_INSERT: begin
        if (keys.size() >= CAPACITY_DEF) begin
          result_q.push_back(mk(ST_FULL, 0, 0, 1));
        end else begin
          pos = 0;
          while (pos < keys.size() && keys[pos] < klo) pos++;
          keys.insert(pos, klo);
          ids.insert(pos, vid);
          result_q.push_back(mk(ST_OK, 0, 0, 1));
        end
      end
      MODE_REMOVE: begin
        for (int i = keys.size() - 1; i >= 0; i--) begin
          if (ids[i] == vid) begin
            keys.delete(i);
            ids.delete(i);
          end
        end
        result_q.push_back(mk(ST_OK, 0, 0, 1));
      end
      MODE_LOOKUP: begin
        if (lim == 0) begin
          result_q.push_back(mk(ST_ZERO_LIM, 0, 0, 1));
        end else begin
          if (lim > MAX_RESULTS_DEF) lim = MAX_RESULTS_DEF;
          n = 0;
          foreach (keys[i]) begin
            if (keys[i] >= klo && keys[i] <= khi && n < lim) begin
              result_q.push_back(mk(ST_OK, 1, ids[i], 0));
              n++;
            end
          end
          if (n == 0) result_q.push_back(mk(ST_OK, 0, 0, 1));
          else result_q[$].last = 1;
        end
      end
      default: result_q.push_back(mk(ST_OK, 0, 0, 1));
    endcase
  endtask

  always @(posedge clk) begin
    index_result_t got, want;
    if (rst) begin
      keys.delete(); ids.delete(); result_q.delete();
    end else begin
      if (s_tvalid && s_tready) apply_command(s_tdata);
      if (m_tvalid && m_tready) begin
        got = {status_t'(m_tdata[1:0]), m_tdata[2], m_tdata[34:3], m_tdata[43:35], m_tlast};
        if (result_q.size() == 0) begin
          report("result transaction with nothing expected");
        end else begin
          want = result_q.pop_front();
          if (got.status != want.status)
            report($sformatf("status %0d want %0d", got.status, want.status));
          if (got.found != want.found)
            report($sformatf("found %0d want %0d", got.found, want.found));
          if (got.match_id != want.match_id)
            report($sformatf("match_id %h want %h", got.match_id, want.match_id));
          if (got.entry_total != want.entry_total)
            report($sformatf("entry_total %0d want %0d", got.entry_total,
                             want.entry_total));
          if (got.last != want.last)
            report($sformatf("tlast %0d want %0d", got.last, want.last));
          if (m_tdata[47:44] != 0) report("nonzero fill bits");
        end
      end
    end
  end

  initial fail_count = 0;
endmodule

>>> bench/sorted_int_range_index_tb.sv
module sorted_int_range_index_tb;
  import sirx_pkg::*;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [175:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [47:0]  m_tdata;
  logic         m_tlast;
  int           fail_count;
  int           pending;
  logic [31:0]  id_pool[8];
  logic signed [63:0] key_pool[8];

  always #6 clk = ~clk;

  sorted_int_range_index u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  sorted_int_range_index_chk u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  // short gaps mostly, sometimes a long one, sometimes none at all
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver stall pattern, re-rolled on each cycle with no stall left
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 0;
    end else begin
      m_tready <= 1;
      if ($urandom_range(0, 9) < 3) stall_left <= gap_len();
    end
  end

  // one command transaction; valid stays high until taken, and drops
  // only when a gap follows or wait_drained stops sending
  task automatic send_command(input mode_t md, input logic signed [63:0] klo,
                              input logic signed [63:0] khi, input logic [31:0] vid,
                              input logic [6:0] lim);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {7'd0, lim, vid, khi, klo, md};
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending and wait for the result stream to drain
  task automatic wait_drained();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic signed [63:0] rand_key();
    case ($urandom_range(0, 3))
      0: return key_pool[$urandom_range(0, 7)];
      1: return {$urandom, $urandom};
      2: return $signed(64'($urandom_range(0, 40))) - 20;
      default: return {$urandom, $urandom} >>> $urandom_range(0, 62);
    endcase
  endfunction

  initial begin
    logic signed [63:0] a, b;
    int p;
    foreach (id_pool[i]) id_pool[i] = $urandom;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = 64'sh8000000000000000;
    key_pool[1] = 64'sh7fffffffffffffff;
    key_pool[2] = 0;
    key_pool[3] = -1;
    repeat (5) @(posedge clk);
    rst <= 0;

    // directed: extremes, every mode, special cases
    send_command(MODE_COUNT, 0, 0, 0, 0);
    send_command(MODE_LOOKUP, key_pool[0], key_pool[1], 0, 64);
    send_command(MODE_INSERT, key_pool[1], 0, 32'hffffffff, 0);
    send_command(MODE_INSERT, key_pool[0], 0, 32'h0, 0);
    send_command(MODE_INSERT, 5, 0, 32'h11, 0);
    send_command(MODE_INSERT, 5, 0, 32'h22, 0);
    send_command(MODE_INSERT, -1, 0, 32'h33, 0);
    send_command(MODE_INSERT, 0, 0, 32'h11, 0);
    send_command(MODE_LOOKUP, key_pool[0], key_pool[1], 0, 7'h7f);
    send_command(MODE_LOOKUP, key_pool[0], key_pool[1], 0, 0);
    send_command(MODE_LOOKUP, 5, 5, 0, 1);
    send_command(MODE_LOOKUP, 6, 4, 0, 10);
    send_command(MODE_LOOKUP, 100, 200, 32'hffffffff, 65);
    send_command(MODE_REMOVE, 0, 0, 32'h11, 0);
    send_command(MODE_REMOVE, 0, 0, 32'h12345678, 0);
    send_command(MODE_LOOKUP, key_pool[0], key_pool[1], 0, 64);
    send_command(MODE_REMOVE, 0, 0, 32'hffffffff, 0);
    send_command(MODE_COUNT, -1, -1, 32'hffffffff, 7'h7f);
    wait_drained();

    // build up the table, then wide lookups and a remove
    for (int i = 0; i < 60; i++) begin
      send_command(MODE_INSERT, rand_key(), {$urandom, $urandom},
                   id_pool[$urandom_range(0, 7)], 7'($urandom));
    end
    send_command(MODE_LOOKUP, key_pool[0], key_pool[1], 0, 64);
    send_command(MODE_LOOKUP, -30, 30, 0, 40);
    send_command(MODE_REMOVE, 0, 0, id_pool[0], 0);

    // random mix
    for (int i = 0; i < 40; i++) begin
      p = $urandom_range(0, 99);
      a = rand_key();
      b = rand_key();
      if ($urandom_range(0, 3) != 0 && a > b) begin
        a = a ^ b; b = a ^ b; a = a ^ b;
      end
      if (p < 45)
        send_command(MODE_INSERT, a, b, id_pool[$urandom_range(0, 7)], 7'($urandom));
      else if (p < 55)
        send_command(MODE_REMOVE, a, b,
                     ($urandom_range(0, 3) == 0) ? $urandom : id_pool[$urandom_range(0, 7)],
                     7'($urandom));
      else if (p < 92)
        send_command(MODE_LOOKUP, a, b, $urandom,
                     ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(1, 127)));
      else
        send_command(MODE_COUNT, a, b, $urandom, 7'($urandom));
      if (i == 20) wait_drained();
    end

    wait_drained();
    repeat (400) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #30000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
